### src/qsl_pkg.sv
// Shared constants, types and state codes for the sorter.
package qsl_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int IN_WIDTH       = 32;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic ins;    // insert the broadcast value in order
    logic shift;  // move every entry one place toward the head
  } cell_cmd_t;

endpackage

### src/qsl_if.sv
// Valid/ready channel interfaces for the sorter's input and result items.
interface qsl_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface qsl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sorted_value;
  logic               last_out;
  logic               overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflow,
                  output ready);
endinterface

### src/qsl_cell.sv
// One cell of the sorting row: holds one entry, ordered insert and shift.
module qsl_cell #(
  parameter int DATA_WIDTH = qsl_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  qsl_pkg::cell_cmd_t           cmd,
  input  logic signed [DATA_WIDTH-1:0] ins_value,
  input  logic                         left_valid,
  input  logic                         left_disp,
  input  logic signed [DATA_WIDTH-1:0] left_value,
  input  logic                         right_valid,
  input  logic signed [DATA_WIDTH-1:0] right_value,
  output logic                         valid,
  output logic                         disp,
  output logic signed [DATA_WIDTH-1:0] value
);
  import qsl_pkg::*;

  logic                         valid_next;
  logic signed [DATA_WIDTH-1:0] value_next;

  // This entry moves one place down when the new value sorts before it.
  assign disp = valid && (ins_value < value);

  always_comb begin
    valid_next = valid;
    value_next = value;
    if (cmd.shift) begin
      valid_next = right_valid;
      value_next = right_value;
    end else if (cmd.ins) begin
      if (left_disp) begin
        valid_next = 1'b1;
        value_next = left_value;
      end else if (disp || (!valid && left_valid)) begin
        valid_next = 1'b1;
        value_next = ins_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

### src/quicksort_lomuto_sorter.sv
// Batch sorter: a row of insertion cells keeps the batch ordered as it loads.
//
// Items are taken one per cycle while the block is loading. Each accepted
// value is broadcast to a row of DEPTH cells; every cell compares it with its
// own entry in the same cycle, so the row is always in ascending order and no
// separate sort pass follows. The item flagged last closes the batch, and the
// block then presents the stored values from the head of the row, smallest
// first, one result item per cycle while the sink is ready; each taken result
// shifts the row one place toward the head. Loading is paced by the single
// broadcast insert per cycle, and draining by the single head register that
// the results leave through. Input is not taken while results are drained.
// Items that arrive with DEPTH elements already stored are dropped, and every
// result of that batch carries overflow. Values are sign-extended or wrapped
// to DATA_WIDTH bits and compared signed at that width; the result is that
// value sign-extended or truncated to 32 bits.
module quicksort_lomuto_sorter #(
  parameter int DEPTH      = qsl_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = qsl_pkg::DATA_WIDTH_DEF
) (
  input logic     clk,
  input logic     rst,
  qsl_in_if.sink  feed,
  qsl_out_if.source result
);
  import qsl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  state_t         state, state_next;
  logic [CW-1:0]  count, count_next;
  logic           overflow_flag, overflow_flag_next;
  cell_cmd_t      cmd;

  logic                         feed_acc;
  logic                         result_acc;
  logic signed [DATA_WIDTH-1:0] ins_value;

  logic                         cell_valid [DEPTH];
  logic                         cell_disp  [DEPTH];
  logic signed [DATA_WIDTH-1:0] cell_value [DEPTH];

  assign feed_acc   = feed.valid && feed.ready;
  assign result_acc = result.valid && result.ready;

  // Bring the 32-bit input to the storage width.
  generate
    if (DATA_WIDTH <= IN_WIDTH) begin : g_in_trunc
      assign ins_value = feed.value[DATA_WIDTH-1:0];
    end else begin : g_in_ext
      assign ins_value = {{(DATA_WIDTH-IN_WIDTH){feed.value[IN_WIDTH-1]}}, feed.value};
    end
  endgenerate

  // Present the head of the row at 32 bits.
  generate
    if (DATA_WIDTH >= IN_WIDTH) begin : g_out_trunc
      assign result.sorted_value = cell_value[0][IN_WIDTH-1:0];
    end else begin : g_out_ext
      assign result.sorted_value =
        {{(IN_WIDTH-DATA_WIDTH){cell_value[0][DATA_WIDTH-1]}}, cell_value[0]};
    end
  endgenerate

  assign result.valid    = (state == ST_DRAIN);
  assign result.last_out = (count == CW'(1));
  assign result.overflow = overflow_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      count         <= '0;
      overflow_flag <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      overflow_flag <= overflow_flag_next;
    end
  end

  always_comb begin
    state_next         = state;
    count_next         = count;
    overflow_flag_next = overflow_flag;
    feed.ready         = 1'b0;
    cmd.ins            = 1'b0;
    cmd.shift          = 1'b0;
    unique case (state)
      ST_LOAD: begin
        feed.ready = 1'b1;
        if (feed_acc) begin
          // Store while there is room; otherwise drop and flag.
          if (count < CW'(DEPTH)) begin
            cmd.ins    = 1'b1;
            count_next = count + CW'(1);
          end else begin
            overflow_flag_next = 1'b1;
          end
          if (feed.last) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (result_acc) begin
          cmd.shift  = 1'b1;
          count_next = count - CW'(1);
          // Final result taken: start the next batch clean.
          if (count == CW'(1)) begin
            state_next         = ST_LOAD;
            overflow_flag_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // The row of cells; the head is cell 0, the smallest entry.
  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                         l_valid;
      logic                         l_disp;
      logic signed [DATA_WIDTH-1:0] l_value;
      logic                         r_valid;
      logic signed [DATA_WIDTH-1:0] r_value;

      if (i == 0) begin : g_head
        assign l_valid = 1'b1;
        assign l_disp  = 1'b0;
        assign l_value = '0;
      end else begin : g_left
        assign l_valid = cell_valid[i-1];
        assign l_disp  = cell_disp[i-1];
        assign l_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign r_valid = 1'b0;
        assign r_value = '0;
      end else begin : g_right
        assign r_valid = cell_valid[i+1];
        assign r_value = cell_value[i+1];
      end

      qsl_cell #(
        .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmd         (cmd),
        .ins_value   (ins_value),
        .left_valid  (l_valid),
        .left_disp   (l_disp),
        .left_value  (l_value),
        .right_valid (r_valid),
        .right_value (r_value),
        .valid       (cell_valid[i]),
        .disp        (cell_disp[i]),
        .value       (cell_value[i])
      );
    end
  endgenerate

  // A batch being drained always has at least one element left.
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (count != '0))
    else $error("drain with empty count");

  // A result is shown only from an occupied head cell.
  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> cell_valid[0])
    else $error("result from empty head cell");

  // Taking the final result leaves the row empty and loading.
  a_batch_done: assert property (@(posedge clk) disable iff (rst)
    (result_acc && result.last_out) |=> (!cell_valid[0] && state == ST_LOAD))
    else $error("row not empty after final result");

  // An empty count while loading means an empty row.
  a_empty_row: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && count == '0) |-> !cell_valid[0])
    else $error("row holds data with zero count");

  // A full row never takes another insert.
  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |-> !cell_valid[DEPTH-1])
    else $error("insert into full row");

endmodule
